@@ rtl/adsr_pkg.sv @@
package adsr_pkg;

  localparam int LevelFracBits = 30;
  localparam int CoeffFracBits = 24;

  // Q1.L level, Q1.C coefficient (coefficient may reach 1.0 and a bit beyond)
  localparam int LevelW   = LevelFracBits + 1;
  localparam int CoeffW   = CoeffFracBits + 1;
  localparam int CfgDataW = LevelW;
  localparam int CfgIdxW  = 2;

  // Difference target - level, product, step and sum widths
  localparam int DiffW = LevelW + 2;
  localparam int ProdW = CoeffW + 1 + DiffW;
  localparam int StepW = ProdW - CoeffFracBits;
  localparam int SumW  = StepW + 1;

  localparam longint LvlOne    = 64'sd1 <<< LevelFracBits;
  localparam longint AtkTarget = (LvlOne * 200 + 63) / 126;   // 1/0.63
  localparam longint RelTarget = LvlOne - AtkTarget;          // 1 - 1/0.63
  localparam longint Silence   = (LvlOne + 50000) / 100000;   // 1e-5

  localparam logic [CoeffW-1:0]  CoeffReset   = CoeffW'(508401);
  localparam logic [LevelW-1:0]  SustainReset = LevelW'(LvlOne / 2);

  typedef enum logic [CfgIdxW-1:0] {
    RegAttackRate   = 2'd0,
    RegDecayRate    = 2'd1,
    RegReleaseRate  = 2'd2,
    RegSustainLevel = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CoeffW-1:0] attack_rate;
    logic [CoeffW-1:0] decay_rate;
    logic [CoeffW-1:0] release_rate;
    logic [LevelW-1:0] sustain_level;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] value;
    logic              attack;
  } env_state_t;

endpackage

@@ rtl/adsr_if.sv @@
interface adsr_in_if import adsr_pkg::*; ();
  logic valid;
  logic ready;
  logic gate_level;
  logic trigger_pulse;

  modport source (output valid, gate_level, trigger_pulse, input ready);
  modport sink   (input valid, gate_level, trigger_pulse, output ready);
endinterface

interface adsr_out_if import adsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] level;
  logic              active;

  modport source (output valid, level, active, input ready);
  modport sink   (input valid, level, active, output ready);
endinterface

@@ rtl/adsr_cfg.sv @@
module adsr_cfg import adsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_rate   <= CoeffReset;
      cfg_q.decay_rate    <= CoeffReset;
      cfg_q.release_rate  <= CoeffReset;
      cfg_q.sustain_level <= SustainReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegAttackRate:   cfg_q.attack_rate   <= cfg_data_i[CoeffW-1:0];
        RegDecayRate:    cfg_q.decay_rate    <= cfg_data_i[CoeffW-1:0];
        RegReleaseRate:  cfg_q.release_rate  <= cfg_data_i[CoeffW-1:0];
        RegSustainLevel: cfg_q.sustain_level <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/adsr_step.sv @@
module adsr_step import adsr_pkg::*; (
  input  cfg_t       cfg_i,
  input  env_state_t state_i,
  input  logic       gate_i,
  input  logic       trig_i,
  output env_state_t state_o,
  output logic       active_o
);

  localparam logic signed [SumW-1:0] SumOne     = SumW'(LvlOne);
  localparam logic signed [SumW-1:0] SumSilence = SumW'(Silence);

  logic                    gate;
  logic                    attack;
  logic [CoeffW-1:0]       coeff;
  logic signed [DiffW-1:0] level_s;
  logic signed [DiffW-1:0] target;
  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod;
  logic signed [StepW-1:0] step;
  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  clamped;

  always_comb begin
    gate    = gate_i | trig_i;
    attack  = state_i.attack | trig_i;
    level_s = $signed({2'b00, state_i.value});
    if (!gate) begin
      target = DiffW'(RelTarget);
      coeff  = cfg_i.release_rate;
    end else if (attack) begin
      target = DiffW'(AtkTarget);
      coeff  = cfg_i.attack_rate;
    end else begin
      target = $signed({2'b00, cfg_i.sustain_level});
      coeff  = cfg_i.decay_rate;
    end
    diff = target - level_s;
    prod = $signed({1'b0, coeff}) * diff;
    // arithmetic shift: floor toward minus infinity
    step = $signed(prod[ProdW-1:CoeffFracBits]);
    sum  = SumW'(level_s) + SumW'(step);

    clamped  = sum;
    active_o = 1'b1;
    if (gate) begin
      if (sum > SumOne) begin
        clamped = SumOne;
        attack  = 1'b0;
      end else if (sum < 0) begin
        clamped = '0;
      end
    end else begin
      if (sum < SumSilence) begin
        clamped  = '0;
        active_o = 1'b0;
      end else if (sum > SumOne) begin
        clamped = SumOne;
      end
    end

    state_o.value  = clamped[LevelW-1:0];
    // a level over one outside attack just saturates; attack flag only clears in attack
    state_o.attack = (gate && (state_i.attack | trig_i)) ? attack
                                                         : state_i.attack;
  end

endmodule

@@ rtl/exponential_adsr_envelope.sv @@
// Channel  Dir  Handshake      Word
// in_i     in   valid/ready    gate_level, trigger_pulse
// out_o    out  valid/ready    level (Q1.30), active
// cfg      in   cfg_we_i       cfg_idx_i selects register, cfg_data_i value
//
// One word per cycle while the result is taken; a taken word goes through the
// input register, then one coefficient multiply-add into the result register.
// The envelope state updates in the same cycle as the result register, so the
// multiply-add with its clamp is the single feedback path.
// Reset clears the envelope, the attack flag, both stages, and loads the
// default coefficients. A stalled result holds; while it waits, a word is taken
// only into an empty input register, then ready stays low until the result goes.
module exponential_adsr_envelope import adsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  adsr_in_if.sink             in_i,
  adsr_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg;
  env_state_t state_q;
  env_state_t state_d;
  logic       active_d;

  logic       s1_valid_q;
  logic       s1_gate_q;
  logic       s1_trig_q;
  logic       out_valid_q;
  logic [LevelW-1:0] out_level_q;
  logic       out_active_q;

  logic       adv;
  logic       fire;
  logic       in_take;

  adsr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  adsr_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .gate_i   (s1_gate_q),
    .trig_i   (s1_trig_q),
    .state_o  (state_d),
    .active_o (active_d)
  );

  assign adv     = !out_valid_q || out_o.ready;
  assign fire    = s1_valid_q && adv;
  assign in_take = in_i.valid && in_i.ready;

  assign in_i.ready   = !s1_valid_q || adv;
  assign out_o.valid  = out_valid_q;
  assign out_o.level  = out_level_q;
  assign out_o.active = out_active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_gate_q <= in_i.gate_level;
      s1_trig_q <= in_i.trigger_pulse;
    end
    if (fire) begin
      out_level_q  <= state_d.value;
      out_active_q <= active_d;
    end
  end

endmodule

@@ rtl/adsr_chk.sv @@
module adsr_chk import adsr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [LevelW-1:0] out_level_i,
  input logic              out_active_i
);

  localparam logic [LevelW-1:0] LevelOne = LevelW'(LvlOne);

  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_level_i <= LevelOne))
    else $error("level above one");

  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_active_i) |-> (out_level_i == '0))
    else $error("inactive word with nonzero level");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_level_i) && $stable(out_active_i)))
    else $error("stalled output word changed");

endmodule

bind exponential_adsr_envelope adsr_chk u_adsr_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_level_i  (out_o.level),
  .out_active_i (out_o.active)
);
